[sv/oai_pkg.sv]
// shared constants and control types for the ordered array insert and remove block
package oai_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam int CMD_W = 3;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int CNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

    typedef struct packed {
        logic take;
        logic dump_step;
    } oai_cmd_t;

    typedef struct packed {
        logic start_dump;
        logic dump_last;
    } oai_stat_t;

endpackage

[sv/oai_datapath.sv]
// entry cells, fill count, edit logic and result register
module oai_datapath #(
    parameter int DEPTH = oai_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  oai_pkg::oai_cmd_t                 ctrl,
    output oai_pkg::oai_stat_t                stat,
    input  logic [oai_pkg::CMD_W-1:0]         s_command,
    input  logic [oai_pkg::POS_W-1:0]         s_position,
    input  logic signed [oai_pkg::VAL_W-1:0]  s_value,
    output logic [oai_pkg::STS_W-1:0]         m_status,
    output logic [oai_pkg::CNT_W-1:0]         m_count,
    output logic signed [oai_pkg::VAL_W-1:0]  m_element,
    output logic                              m_last
);
    import oai_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = (FW > POS_W) ? FW : POS_W;

    logic signed [VAL_W-1:0] cells_reg [DEPTH];
    logic signed [VAL_W-1:0] cells_next [DEPTH];
    logic [FW-1:0]           fill_reg, fill_next;
    logic [IW-1:0]           idx_reg, idx_next;

    logic [STS_W-1:0]        sts_reg, sts_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VAL_W-1:0] elem_reg, elem_next;
    logic                    last_reg, last_next;

    logic [CW-1:0] pos_ext, fill_ext, ins_pos;
    logic          ins_range, is_full, rem_range;
    logic          do_ins, do_rem;
    logic [STS_W-1:0] edit_sts;

    assign pos_ext   = CW'(s_position);
    assign fill_ext  = CW'(fill_reg);
    assign ins_pos   = (s_command == CMD_APPEND) ? fill_ext : pos_ext;
    assign ins_range = ins_pos > fill_ext;
    assign is_full   = fill_ext == CW'(DEPTH);
    assign rem_range = pos_ext >= fill_ext;

    assign stat.start_dump = (s_command == CMD_DUMP) && (fill_reg != '0);
    assign stat.dump_last  = (FW'(idx_reg) + FW'(1)) == fill_reg;

    always_comb begin
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        edit_sts  = STS_OK;
        fill_next = fill_reg;
        case (s_command)
            CMD_APPEND, CMD_INSERT: begin
                if (ins_range) begin
                    edit_sts = STS_RANGE;
                end else if (is_full) begin
                    edit_sts = STS_FULL;
                end else begin
                    do_ins    = 1'b1;
                    fill_next = fill_reg + FW'(1);
                end
            end
            CMD_REMOVE: begin
                if (rem_range) begin
                    edit_sts = STS_RANGE;
                end else begin
                    do_rem    = 1'b1;
                    fill_next = fill_reg - FW'(1);
                end
            end
            CMD_CLEAR: begin
                fill_next = '0;
            end
            CMD_DUMP: begin
                if (fill_reg == '0) begin
                    edit_sts = STS_EMPTY;
                end
            end
            default: begin
                edit_sts = STS_OK;
            end
        endcase
    end

    // per-cell shift: insert pulls from below, remove pulls from above
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
            if (ctrl.take && do_ins) begin
                if (CW'(i) == ins_pos) begin
                    cells_next[i] = s_value;
                end else if (i > 0 && CW'(i) > ins_pos) begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (ctrl.take && do_rem) begin
                if (i < DEPTH - 1 && CW'(i) >= pos_ext) begin
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        sts_next  = sts_reg;
        cnt_next  = cnt_reg;
        elem_next = elem_reg;
        last_next = last_reg;
        if (ctrl.take) begin
            idx_next = '0;
            if (!stat.start_dump) begin
                sts_next  = edit_sts;
                cnt_next  = CNT_W'(fill_next);
                elem_next = '0;
                last_next = 1'b1;
            end
        end else if (ctrl.dump_step) begin
            idx_next  = idx_reg + IW'(1);
            sts_next  = STS_OK;
            cnt_next  = CNT_W'(fill_reg);
            elem_next = cells_reg[idx_reg];
            last_next = stat.dump_last;
        end
    end

    always_ff @(posedge aclk) begin
        cells_reg <= cells_next;
        idx_reg   <= idx_next;
        sts_reg   <= sts_next;
        cnt_reg   <= cnt_next;
        elem_reg  <= elem_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (ctrl.take) begin
            fill_reg <= fill_next;
        end
    end

    assign m_status  = sts_reg;
    assign m_count   = cnt_reg;
    assign m_element = elem_reg;
    assign m_last    = last_reg;

endmodule

[sv/oai_ctrl.sv]
// controller: request intake, dump sequencing and result valid
module oai_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  oai_pkg::oai_stat_t stat,
    output oai_pkg::oai_cmd_t  ctrl
);
    import oai_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic state_reg, state_next;
    logic valid_reg, valid_next;
    logic out_free;

    assign out_free       = !valid_reg || m_ready;
    assign s_ready        = (state_reg == S_IDLE) && out_free;
    assign ctrl.take      = s_valid && s_ready;
    assign ctrl.dump_step = (state_reg == S_DUMP) && out_free;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctrl.take) begin
                    valid_next = !stat.start_dump;
                    if (stat.start_dump) begin
                        state_next = S_DUMP;
                    end
                end else if (m_ready) begin
                    valid_next = 1'b0;
                end
            end
            S_DUMP: begin
                if (ctrl.dump_step) begin
                    valid_next = 1'b1;
                    if (stat.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;

    a_edit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.take && !stat.start_dump |=> m_valid && state_reg == S_IDLE)
        else $error("edit request gave no result");

    a_dump_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.take && stat.start_dump |=> state_reg == S_DUMP)
        else $error("dump did not start");

    a_dump_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.dump_step && stat.dump_last |=> state_reg == S_IDLE && m_valid)
        else $error("dump did not end on its last entry");

    a_no_take_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |-> !ctrl.take)
        else $error("request taken during dump");

endmodule

[sv/ordered_array_insert_remove_top.sv]
// top level of the ordered array insert and remove block
// Holds an ordered list of up to DEPTH signed 32-bit entries in a row of registers with
// per-cell shift logic, so append, insert, remove and clear each give their single result
// in the result register on the next cycle. A new request is taken whenever no dump is
// running and the result register is empty or being taken, so edit requests sustain one
// per cycle against a ready sink. A dump enters the dump state and then streams one entry
// per cycle while the sink is ready, count entries in all; it is paced by the single
// result register. Entry cells have no reset and are only read below the count.
module ordered_array_insert_remove_top #(
    parameter int DEPTH = oai_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [oai_pkg::CMD_W-1:0]         s_command,
    input  logic [oai_pkg::POS_W-1:0]         s_position,
    input  logic signed [oai_pkg::VAL_W-1:0]  s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [oai_pkg::STS_W-1:0]         m_status,
    output logic [oai_pkg::CNT_W-1:0]         m_count,
    output logic signed [oai_pkg::VAL_W-1:0]  m_element,
    output logic                              m_last
);
    import oai_pkg::*;

    oai_cmd_t  ctrl;
    oai_stat_t stat;

    oai_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    oai_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .s_command  (s_command),
        .s_position (s_position),
        .s_value    (s_value),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_element  (m_element),
        .m_last     (m_last)
    );

endmodule
